// ===== design/nrs_pkg.sv =====
// Package: shared constants, mode codes and sequencer state type for the station search core.
`default_nettype none
package nrs_pkg;

    localparam int MAX_ROUTES = 256;
    localparam int ADDR_W     = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int COUNT_W    = $clog2(MAX_ROUTES + 1);
    localparam int STATION_W  = 32;
    localparam int DIST_W     = 32;
    localparam int ENTRY_W    = 2 * STATION_W;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_GO  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_SCAN,
        ST_FINISH
    } nrs_state_t;

endpackage
`default_nettype wire

// ===== design/nearest_reachable_station_core.sv =====
// Top level: route table and sequencer that finds the nearest reachable station distance.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  input   | s_valid s_ready s_mode s_start_station     | in
//          | s_finish_station                          |
//  result  | m_valid m_ready m_distance m_overflowed   | out
//
// ADD word: written to the route RAM if the table has room, else sets the overflow flag; no result.
// GO word: first the direct distance, then one table entry per cycle through the
// single subtract/compare unit, paced by the RAM read port. ready is low while a
// GO word is being scanned.
// Reset clears the route count, the overflow flag and the output valid; the RAM
// needs no clearing since only entries below the count are read.
// A result waiting on m_ready holds the sequencer in its last step.
`default_nettype none
module nearest_reachable_station_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_mode,
    input  wire logic signed [nrs_pkg::STATION_W-1:0]   s_start_station,
    input  wire logic signed [nrs_pkg::STATION_W-1:0]   s_finish_station,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic             [nrs_pkg::DIST_W-1:0]      m_distance,
    output logic                                        m_overflowed
);
    import nrs_pkg::*;

    nrs_state_t state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic signed [STATION_W-1:0] start_reg, start_next;
    logic signed [STATION_W-1:0] finish_reg, finish_next;
    logic [DIST_W-1:0]  best_reg, best_next;
    logic               m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]  m_dist_reg, m_dist_next;
    logic               m_ovf_reg, m_ovf_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic signed [STATION_W-1:0] end_a, end_b, other, operand;
    logic               hit;
    logic signed [STATION_W:0] diff;
    logic [STATION_W:0] diff_abs;
    logic [DIST_W-1:0]  gap;
    logic               lt;
    logic               in_acc;
    logic               last_entry;
    logic               out_free;

    nrs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ROUTES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata({s_start_station, s_finish_station}),
        .rdata(ram_rdata)
    );

    assign end_a = ram_rdata[ENTRY_W-1:STATION_W];
    assign end_b = ram_rdata[STATION_W-1:0];

    // Shared unit: pick the far end of a matching route, take |finish - x|, compare.
    always_comb begin
        hit      = (end_a == start_reg) || (end_b == start_reg);
        other    = (end_a == start_reg) ? end_b : end_a;
        operand  = (state_reg == ST_DIRECT) ? start_reg : other;
        diff     = {finish_reg[STATION_W-1], finish_reg} - {operand[STATION_W-1], operand};
        diff_abs = diff[STATION_W] ? (~diff + 1'b1) : diff;
        gap      = diff_abs[DIST_W-1:0];
        lt       = gap < best_reg;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_acc     = s_valid && s_ready;
    assign last_entry = ({1'b0, idx_reg} == (count_reg - 1'b1));
    assign out_free   = !m_valid_reg || m_ready;
    assign ram_we     = in_acc && (s_mode == MODE_ADD) && (count_reg < COUNT_W'(MAX_ROUTES));

    always_comb begin
        case (state_reg)
            ST_IDLE:   ram_addr = count_reg[ADDR_W-1:0];
            ST_SCAN:   ram_addr = idx_reg + 1'b1;
            default:   ram_addr = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        finish_next  = finish_reg;
        best_next    = best_reg;
        m_valid_next = m_valid_reg;
        m_dist_next  = m_dist_reg;
        m_ovf_next   = m_ovf_reg;

        // drop the output word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_mode == MODE_ADD) begin
                        if (ram_we) begin
                            count_next = count_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        start_next  = s_start_station;
                        finish_next = s_finish_station;
                        idx_next    = '0;
                        state_next  = ST_DIRECT;
                    end
                end
            end
            ST_DIRECT: begin
                best_next  = gap;
                state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (hit && lt) begin
                    best_next = gap;
                end
                idx_next = idx_reg + 1'b1;
                if (last_entry) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_dist_next  = best_reg;
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        finish_reg <= finish_next;
        best_reg   <= best_next;
        m_dist_reg <= m_dist_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_distance   = m_dist_reg;
    assign m_overflowed = m_ovf_reg;

    a_write_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE) && (count_reg < COUNT_W'(MAX_ROUTES)))
        else $error("route write outside idle or past table end");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_ROUTES))
        else $error("route count beyond table depth");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared without reset");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished search did not present a result");

endmodule
`default_nettype wire

// ===== design/nrs_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module nrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
